FILE: rtl/dq_pkg.sv
// dq_pkg: shared types and constants for the int32 to bfloat16 dequantizer
// no dependencies
package dq_pkg;

    localparam logic [15:0] BF16_QNAN  = 16'h7FC0;
    localparam logic [15:0] BF16_INF   = 16'h7F80;
    localparam logic [15:0] BF16_QUIET = 16'h0040;

    // special-case class decided at the first stage
    typedef enum logic [1:0] {
        CLS_NORMAL = 2'd0,
        CLS_NAN    = 2'd1,
        CLS_INF    = 2'd2,
        CLS_QNAN   = 2'd3
    } cls_t;

endpackage

FILE: rtl/int32_scale_dequant_to_bf16.sv
// int32_scale_dequant_to_bf16: top level, five-stage float pipeline
// depends on dq_pkg
//
// Usage
//   s_ channel: one request carries s_acc_value (signed int32) and s_scale_bits
//   (float32 bits). m_ channel returns m_result_bits, the bfloat16 bits of
//   acc * scale / 256 with round-to-nearest-even at every float32 step.
//   Both channels use valid/ready; a request is taken when valid and ready
//   are both high.
//   Throughput is one request per cycle: every stage advances together
//   whenever the output register is empty or being drained.
//   The stages are: magnitude and leading-zero count, accumulator rounding
//   and mantissa product, product normalization and float32 rounding with
//   gradual underflow, scaling by 2^-8 with float32 rounding, bfloat16
//   rounding and packing.
//   A synchronous active-low aresetn clears all valid bits; no request is
//   in flight afterwards.
//   When m_ready is low with a result waiting, the whole pipeline holds and
//   s_ready drops, so nothing is lost or repeated.
module int32_scale_dequant_to_bf16 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_acc_value,
    input  logic [31:0] s_scale_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_result_bits
);

    logic adv;
    logic [4:0] v_reg;

    assign adv     = !v_reg[4] || m_ready;
    assign s_ready = adv;
    assign m_valid = v_reg[4];

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[3:0], s_valid};
        end
    end

    // stage 1: classify, int to float32 (exact integer mantissa kept, rnd later)
    logic [31:0] mag1;
    logic [4:0]  lz1;
    logic        zero1;
    always_comb begin
        mag1 = s_acc_value[31] ? (~s_acc_value + 32'd1) : s_acc_value;
        lz1 = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (mag1[i]) lz1 = 5'(31 - i);
        end
        zero1 = (mag1 == 32'd0);
    end

    dq_pkg::cls_t cls1_reg;
    logic [15:0]  spec1_reg;
    logic         sgn1_reg, az1_reg;
    logic [31:0]  mag1_reg;
    logic [4:0]   lz1_reg;
    logic [31:0]  sb1_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (s_scale_bits[30:23] == 8'hFF) begin
                if (s_scale_bits[22:0] != 23'd0) begin
                    cls1_reg  <= dq_pkg::CLS_NAN;
                end else if (zero1) begin
                    cls1_reg  <= dq_pkg::CLS_QNAN;
                end else begin
                    cls1_reg  <= dq_pkg::CLS_INF;
                end
            end else begin
                cls1_reg <= dq_pkg::CLS_NORMAL;
            end
            spec1_reg <= s_scale_bits[31:16] | dq_pkg::BF16_QUIET;
            sgn1_reg  <= s_acc_value[31] ^ s_scale_bits[31];
            az1_reg   <= zero1;
            mag1_reg  <= mag1;
            lz1_reg   <= lz1;
            sb1_reg   <= s_scale_bits;
        end
    end

    // stage 2: round int to 24 bits, normalize scale (subnormal too)
    logic [31:0] nm2;
    logic [24:0] ar2;
    logic [23:0] am2;
    logic signed [10:0] ae2;
    logic [23:0] sm2;
    logic [4:0]  slz2;
    logic signed [10:0] se2;
    logic        sz2;
    always_comb begin
        nm2 = mag1_reg << lz1_reg;
        ar2 = {1'b0, nm2[31:8]} +
              25'(nm2[7] && (nm2[6:0] != 7'd0 || nm2[8]));
        if (ar2[24]) begin
            am2 = ar2[24:1];
            ae2 = 11'sd32 - 11'(lz1_reg);
        end else begin
            am2 = ar2[23:0];
            ae2 = 11'sd31 - 11'(lz1_reg);
        end
        slz2 = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (sb1_reg[i]) slz2 = 5'(23 - i);
        end
        sz2 = (sb1_reg[30:0] == 31'd0);
        if (sb1_reg[30:23] == 8'd0) begin
            sm2 = {1'b0, sb1_reg[22:0]} << slz2;
            se2 = -11'sd126 - 11'(slz2);
        end else begin
            sm2 = {1'b1, sb1_reg[22:0]};
            se2 = 11'(sb1_reg[30:23]) - 11'sd127;
        end
    end

    dq_pkg::cls_t cls2_reg;
    logic [15:0]  spec2_reg;
    logic         sgn2_reg, z2_reg;
    logic [47:0]  p2_reg;
    logic signed [10:0] e2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            cls2_reg  <= cls1_reg;
            spec2_reg <= spec1_reg;
            sgn2_reg  <= sgn1_reg;
            z2_reg    <= az1_reg || sz2;
            p2_reg    <= am2 * sm2;
            e2_reg    <= ae2 + se2;
        end
    end

    // stage 3: normalize the product to 1.x and round it to float32
    // product value = p * 2^(e-46); subnormal if biased exp <= 0
    logic [47:0] pn3;
    logic signed [10:0] pe3;
    logic [6:0]  sh3;
    logic [48:0] sx3;
    logic [24:0] r3;
    logic [23:0] m3;
    logic signed [10:0] e3;
    always_comb begin
        if (p2_reg[47]) begin
            pn3 = p2_reg;
            pe3 = e2_reg + 11'sd1;
        end else begin
            pn3 = {p2_reg[46:0], 1'b0};
            pe3 = e2_reg;
        end
        if (pe3 > -11'sd127) sh3 = 7'd0;
        else if (pe3 < -11'sd150) sh3 = 7'd25;
        else sh3 = 7'(-11'sd126 - pe3);
        sx3 = {pn3, 1'b0} >> sh3;
        r3 = {1'b0, sx3[48:25]} +
             25'(sx3[24] && ((sx3[23:0] != 24'd0) || sx3[25] ||
                 (({pn3, 1'b0} & ~(49'h1FFFFFFFFFFFF << sh3)) != 49'd0)));
        if (r3[24]) begin
            m3 = r3[24:1];
            e3 = pe3 + 11'sd1;
        end else begin
            m3 = r3[23:0];
            e3 = (m3[23]) ? pe3 : -11'sd127;
        end
        if (sh3 != 7'd0) e3 = m3[23] ? -11'sd126 : -11'sd127;
    end

    dq_pkg::cls_t cls3_reg;
    logic [15:0]  spec3_reg;
    logic         sgn3_reg, z3_reg, inf3_reg;
    logic [23:0]  m3_reg;
    logic signed [10:0] e3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            cls3_reg  <= cls2_reg;
            spec3_reg <= spec2_reg;
            sgn3_reg  <= sgn2_reg;
            z3_reg    <= z2_reg;
            m3_reg    <= m3;
            e3_reg    <= e3;
            inf3_reg  <= (e3 > 11'sd127);
        end
    end

    // stage 4: scale by 2^-8 and round again to float32 (subnormal shift)
    logic [6:0]  sh4b;
    logic [24:0] sx4b;
    logic [23:0] rm4;
    logic [31:0] f4;
    always_comb begin
        // value m3 * 2^(e3-23) times 2^-8
        if (m3_reg == 24'd0) begin
            sh4b = 7'd0;
        end else if (m3_reg[23] && (e3_reg - 11'sd8) > -11'sd127) begin
            sh4b = 7'd0;
        end else begin
            sh4b = m3_reg[23] ? 7'(-11'sd126 - (e3_reg - 11'sd8))
                              : 7'd8;
            if (sh4b > 7'd25) sh4b = 7'd25;
        end
        sx4b = {m3_reg, 1'b0} >> sh4b;
        rm4 = sx4b[24:1] + 24'(sx4b[0] &&
              ((({m3_reg, 1'b0} & ~(25'h1FFFFFF << sh4b)) != 25'd0) || sx4b[1]));
        if (sh4b == 7'd0 && m3_reg[23]) begin
            f4 = {1'b0, 8'(e3_reg - 11'sd8 + 11'sd127), m3_reg[22:0]};
        end else begin
            // result subnormal (rm4[23] set means it rounded up to min normal)
            f4 = {1'b0, 8'(rm4[23]), rm4[22:0]};
        end
        if (z3_reg) f4 = 32'd0;
        if (inf3_reg && !z3_reg) f4 = 32'h7F800000;
    end

    dq_pkg::cls_t cls4_reg;
    logic [15:0]  spec4_reg;
    logic         sgn4_reg;
    logic [31:0]  f4_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            cls4_reg  <= cls3_reg;
            spec4_reg <= spec3_reg;
            sgn4_reg  <= sgn3_reg;
            f4_reg    <= f4;
        end
    end

    // stage 5: bfloat16 rounding and special cases
    logic [31:0] rb5;
    logic [15:0] out5;
    always_comb begin
        rb5 = f4_reg + 32'h7FFF + 32'(f4_reg[16]);
        case (cls4_reg)
            dq_pkg::CLS_NAN:  out5 = spec4_reg;
            dq_pkg::CLS_QNAN: out5 = dq_pkg::BF16_QNAN;
            dq_pkg::CLS_INF:  out5 = dq_pkg::BF16_INF | {sgn4_reg, 15'd0};
            default: begin
                if (f4_reg[30:23] == 8'd0) out5 = {sgn4_reg, 15'd0};
                else if (f4_reg[30:23] == 8'hFF) out5 = {sgn4_reg, f4_reg[30:16]};
                else out5 = {sgn4_reg, rb5[30:16]};
            end
        endcase
    end

    logic [15:0] res_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= out5;
        end
    end
    assign m_result_bits = res_reg;

endmodule
